// ----- src/c2dsw_pkg.sv -----
package c2dsw_pkg;

  // kernel and stream geometry
  localparam int KERNEL_SIZE = 5;
  localparam int MAX_WIDTH   = 4096;
  localparam int COEF_BITS   = 16;

  localparam int TAPS   = KERNEL_SIZE * KERNEL_SIZE;
  localparam int LINES  = KERNEL_SIZE - 1;
  localparam int ADDR_W = $clog2(MAX_WIDTH);

  // field widths
  localparam int PIX_W    = 8;
  localparam int IDX_W    = 5;
  localparam int COEFIN_W = 16;
  localparam int CFG_W    = 13;
  localparam int COUNT_W  = 12;
  localparam int OUT_W    = 24;

  // arithmetic widths
  localparam int PROD_W = PIX_W + COEF_BITS;
  localparam int SUM_W  = PROD_W + $clog2(TAPS);
  localparam int Q_W    = SUM_W + 16;
  localparam int WORD_W = LINES * PIX_W;

  localparam logic [OUT_W-1:0]   SAT_MAX   = {OUT_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [CFG_W-1:0]   PW_RESET  = CFG_W'(516);

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                command;
    logic [IDX_W-1:0]    coef_index;
    logic [COEFIN_W-1:0] coef_value;
    logic [PIX_W-1:0]    pixel;
    logic                first_of_frame;
  } item_t;

  typedef struct packed {
    logic [OUT_W-1:0]   filtered_value;
    logic [COUNT_W-1:0] out_row;
    logic [COUNT_W-1:0] out_col;
    logic               saturated;
  } result_t;

endpackage

// ----- src/conv2d_sliding_window_top.sv -----
// streaming valid 2-d convolution, 5x5 kernel, line buffers in one memory
//
// src channel (src_valid / src_stall / src_data): one transfer per item. a
// load item (command CMD_LOAD) writes one Q0.16 coefficient; a pixel item
// feeds one padded 8-bit pixel in raster order, first_of_frame restarting
// the row and column counters. loads may be mixed with pixels in any order.
// res channel (res_valid / res_stall / res_data): one Q8.16 result per pixel
// once the window holds full kernel rows and columns, saturated and flagged.
// cfg channel (cfg_valid / cfg_ready / cfg_data): padded row width, always
// ready, to be written while no item is in flight.
// throughput: one item per clock unless res_stall backs up the pipeline.
// the line-buffer memory is read when a pixel is taken and written back
// when the column stage advances; a same-column access by the next pixel
// is forwarded, so back-to-back pixels never wait. a result is registered
// after memory read, window and multipliers, row sums, total, saturation.
// reset clears the counters, window, coefficients and width (516). memory
// contents are not cleared. a stalled receiver holds the output register;
// bubbles inside the pipeline still close up, after which src_stall rises.
module conv2d_sliding_window_top
  import c2dsw_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             src_valid,
  output logic             src_stall,
  input  item_t            src_data,
  output logic             res_valid,
  input  logic             res_stall,
  output result_t          res_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  // configuration and counters
  logic [CFG_W-1:0]   padded_width;
  logic [COUNT_W-1:0] column_count;
  logic [COUNT_W-1:0] row_count;

  // line buffer: one word per column, line kr in byte kr
  logic [WORD_W-1:0] line_mem [MAX_WIDTH];
  logic [WORD_W-1:0] rd_word;

  // column stage
  logic               s1_valid;
  item_t              s1_item;
  logic [ADDR_W-1:0]  s1_addr;
  logic               s1_emit;
  logic [COUNT_W-1:0] s1_row;
  logic [COUNT_W-1:0] s1_col;
  logic               s1_use_fwd;
  logic [WORD_W-1:0]  s1_fwd_word;

  // window and coefficients
  logic [PIX_W-1:0]     window      [KERNEL_SIZE][KERNEL_SIZE];
  logic [PIX_W-1:0]     window_next [KERNEL_SIZE][KERNEL_SIZE];
  logic [COEF_BITS-1:0] kernel_store [TAPS];

  // product stage
  logic               sp_valid;
  logic [PROD_W-1:0]  prod [TAPS];
  logic [COUNT_W-1:0] sp_row;
  logic [COUNT_W-1:0] sp_col;

  // row-sum stage
  logic               ss_valid;
  logic [SUM_W-1:0]   psum      [KERNEL_SIZE];
  logic [SUM_W-1:0]   psum_next [KERNEL_SIZE];
  logic [COUNT_W-1:0] ss_row;
  logic [COUNT_W-1:0] ss_col;

  // handshake and flow
  logic src_take;
  logic take_pixel;
  logic out_free;
  logic ss_free;
  logic sp_free;
  logic s1_adv;
  logic s1_to_sp;
  logic s1_wr;

  // counter front end
  logic [CFG_W-1:0]   eff_width;
  logic [COUNT_W-1:0] c0;
  logic [COUNT_W-1:0] r0;
  logic [CFG_W-1:0]   c0_inc;
  logic [ADDR_W-1:0]  rd_addr;

  // column assembly
  logic [WORD_W-1:0] rd_col;
  logic [PIX_W-1:0]  col [KERNEL_SIZE];
  logic [WORD_W-1:0] wr_word;

  // final sum
  logic [SUM_W-1:0] total;
  logic [Q_W-1:0]   q_val;

  assign cfg_ready = 1'b1;

  // pipeline moves forward wherever the next stage is free or draining
  assign out_free  = !res_valid || !res_stall;
  assign ss_free   = !ss_valid || out_free;
  assign sp_free   = !sp_valid || ss_free;
  assign s1_adv    = s1_valid && (!s1_emit || sp_free);
  assign s1_to_sp  = s1_adv && s1_emit;
  assign s1_wr     = s1_adv && (s1_item.command == CMD_PIXEL);
  assign src_stall = s1_valid && !s1_adv;
  assign src_take  = src_valid && !src_stall;
  assign take_pixel = src_take && (src_data.command == CMD_PIXEL);

  // effective width: zero acts as one, clipped at the memory depth
  always_comb begin
    if (padded_width == '0) begin
      eff_width = CFG_W'(1);
    end else if (padded_width > CFG_W'(MAX_WIDTH)) begin
      eff_width = CFG_W'(MAX_WIDTH);
    end else begin
      eff_width = padded_width;
    end
  end

  assign c0      = src_data.first_of_frame ? '0 : column_count;
  assign r0      = src_data.first_of_frame ? '0 : row_count;
  assign c0_inc  = CFG_W'(c0) + CFG_W'(1);
  assign rd_addr = c0[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      padded_width <= PW_RESET;
      column_count <= '0;
      row_count    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        padded_width <= cfg_data;
      end
      if (take_pixel) begin
        if (c0_inc >= eff_width) begin
          column_count <= '0;
          row_count    <= (r0 < COUNT_MAX) ? r0 + COUNT_W'(1) : r0;
        end else begin
          column_count <= c0_inc[COUNT_W-1:0];
          row_count    <= r0;
        end
      end
    end
  end

  // memory: read on pixel transfer, write back when the column stage leaves
  always_ff @(posedge clk) begin
    if (take_pixel) begin
      rd_word <= line_mem[rd_addr];
    end
    if (s1_wr) begin
      line_mem[s1_addr] <= wr_word;
    end
  end

  // column stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (src_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // column stage payload; a write-back to the column just read is forwarded
  always_ff @(posedge clk) begin
    if (src_take) begin
      s1_item     <= src_data;
      s1_addr     <= rd_addr;
      s1_emit     <= (src_data.command == CMD_PIXEL) &&
                     (r0 >= COUNT_W'(LINES)) && (c0 >= COUNT_W'(LINES));
      s1_row      <= r0 - COUNT_W'(LINES);
      s1_col      <= c0 - COUNT_W'(LINES);
      s1_use_fwd  <= s1_wr && (s1_addr == rd_addr);
      s1_fwd_word <= wr_word;
    end
  end

  // assemble the new column and the shifted line-buffer word
  assign rd_col = s1_use_fwd ? s1_fwd_word : rd_word;

  always_comb begin
    for (int kr = 0; kr < LINES; kr++) begin
      col[kr] = rd_col[kr*PIX_W +: PIX_W];
    end
    col[LINES] = s1_item.pixel;
    for (int kr = 0; kr < LINES; kr++) begin
      wr_word[kr*PIX_W +: PIX_W] = col[kr+1];
    end
  end

  // window shifts left, new column enters on the right
  always_comb begin
    for (int kr = 0; kr < KERNEL_SIZE; kr++) begin
      for (int kc = 0; kc < KERNEL_SIZE - 1; kc++) begin
        window_next[kr][kc] = window[kr][kc+1];
      end
      window_next[kr][KERNEL_SIZE-1] = col[kr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int kr = 0; kr < KERNEL_SIZE; kr++) begin
        for (int kc = 0; kc < KERNEL_SIZE; kc++) begin
          window[kr][kc] <= '0;
        end
      end
      for (int t = 0; t < TAPS; t++) begin
        kernel_store[t] <= '0;
      end
    end else if (s1_adv) begin
      if (s1_item.command == CMD_PIXEL) begin
        window <= window_next;
      end else begin
        // out-of-range index matches no tap and is dropped
        for (int t = 0; t < TAPS; t++) begin
          if (32'(s1_item.coef_index) == t) begin
            kernel_store[t] <= COEF_BITS'(s1_item.coef_value);
          end
        end
      end
    end
  end

  // one multiplier per tap, fed from the updated window
  always_ff @(posedge clk) begin
    if (s1_to_sp) begin
      for (int kr = 0; kr < KERNEL_SIZE; kr++) begin
        for (int kc = 0; kc < KERNEL_SIZE; kc++) begin
          prod[kr*KERNEL_SIZE + kc] <= PROD_W'(window_next[kr][kc]) *
                                       PROD_W'(kernel_store[kr*KERNEL_SIZE + kc]);
        end
      end
      sp_row <= s1_row;
      sp_col <= s1_col;
    end
  end

  // per-row sums
  always_comb begin
    for (int kr = 0; kr < KERNEL_SIZE; kr++) begin
      psum_next[kr] = '0;
      for (int kc = 0; kc < KERNEL_SIZE; kc++) begin
        psum_next[kr] = psum_next[kr] + SUM_W'(prod[kr*KERNEL_SIZE + kc]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sp_valid && ss_free) begin
      psum   <= psum_next;
      ss_row <= sp_row;
      ss_col <= sp_col;
    end
  end

  // total, conversion to Q8.16 and saturation
  always_comb begin
    total = '0;
    for (int kr = 0; kr < KERNEL_SIZE; kr++) begin
      total = total + psum[kr];
    end
    q_val = (Q_W'(total) << 16) >> COEF_BITS;
  end

  always_ff @(posedge clk) begin
    if (ss_valid && out_free) begin
      if (q_val > Q_W'(SAT_MAX)) begin
        res_data.filtered_value <= SAT_MAX;
        res_data.saturated      <= 1'b1;
      end else begin
        res_data.filtered_value <= q_val[OUT_W-1:0];
        res_data.saturated      <= 1'b0;
      end
      res_data.out_row <= ss_row;
      res_data.out_col <= ss_col;
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      sp_valid  <= 1'b0;
      ss_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (s1_to_sp) begin
        sp_valid <= 1'b1;
      end else if (ss_free) begin
        sp_valid <= 1'b0;
      end
      if (sp_valid && ss_free) begin
        ss_valid <= 1'b1;
      end else if (out_free) begin
        ss_valid <= 1'b0;
      end
      if (ss_valid && out_free) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // forwarding only ever comes from a pixel that wrote back
  a_fwd_from_pixel: assert property (@(posedge clk) disable iff (rst)
    (take_pixel && s1_valid && (s1_item.command == CMD_LOAD)) |=> !s1_use_fwd)
    else $error("forwarded line-buffer word from a load item");

  // a frame start leaves the counters at the first or second position
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (take_pixel && src_data.first_of_frame) |=>
      (column_count <= COUNT_W'(1) && row_count <= COUNT_W'(1)))
    else $error("counters not restarted by first_of_frame");

  // column counter stays inside the line-buffer depth
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    32'(column_count) < MAX_WIDTH)
    else $error("column counter beyond line-buffer depth");

  // every transfer lands in the column stage
  a_take_to_s1: assert property (@(posedge clk) disable iff (rst)
    src_take |=> s1_valid)
    else $error("accepted item lost before column stage");

endmodule

// ----- tb/sv/conv2d_sliding_window_checker.sv -----
module conv2d_sliding_window_checker
  import c2dsw_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             src_valid,
  input  logic             src_stall,
  input  item_t            src_data,
  input  logic             res_valid,
  input  logic             res_stall,
  input  result_t          res_data,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  output int               pending,
  output int               fail_count,
  output int               checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow copy of the block state
  logic [PIX_W-1:0]     line_mem [LINES][MAX_WIDTH];
  logic [PIX_W-1:0]     win      [KERNEL_SIZE][KERNEL_SIZE];
  logic [COEF_BITS-1:0] coefs    [TAPS];
  logic [COUNT_W-1:0]   col_cnt;
  logic [COUNT_W-1:0]   row_cnt;
  logic [CFG_W-1:0]     width_reg;

  result_t conv_out_q [$];
  int      n_fail;
  int      n_checked;

  function automatic void clear_shadow();
    foreach (line_mem[i, j]) line_mem[i][j] = '0;
    foreach (win[i, j]) win[i][j] = '0;
    foreach (coefs[i]) coefs[i] = '0;
    col_cnt   = '0;
    row_cnt   = '0;
    width_reg = PW_RESET;
  endfunction

  function automatic void store_coef(input item_t it);
    // indexes past the last tap are dropped
    if (it.coef_index < TAPS) coefs[it.coef_index] = it.coef_value;
  endfunction

  // one pixel through line buffers and window, queueing the filtered output
  function automatic void slide_pixel(input item_t it);
    logic [PIX_W-1:0] column [KERNEL_SIZE];
    logic [63:0]      acc;
    logic [63:0]      q;
    result_t          want;
    int               c;
    int               r;
    int               w;
    if (it.first_of_frame) begin
      col_cnt = '0;
      row_cnt = '0;
    end
    if (width_reg == '0) w = 1;
    else if (width_reg > MAX_WIDTH) w = MAX_WIDTH;
    else w = int'(width_reg);
    c = int'(col_cnt);
    r = int'(row_cnt);

    for (int kr = 0; kr < LINES; kr++) column[kr] = line_mem[kr][c];
    column[LINES] = it.pixel;
    for (int kr = 0; kr < LINES; kr++) line_mem[kr][c] = column[kr+1];
    for (int kr = 0; kr < KERNEL_SIZE; kr++) begin
      for (int kc = 0; kc < KERNEL_SIZE - 1; kc++) win[kr][kc] = win[kr][kc+1];
      win[kr][KERNEL_SIZE-1] = column[kr];
    end

    if (c + 1 >= w) begin
      col_cnt = '0;
      if (row_cnt != COUNT_MAX) row_cnt = row_cnt + 1'b1;
    end else begin
      col_cnt = COUNT_W'(c + 1);
    end

    if (r < LINES || c < LINES) return;

    acc = '0;
    for (int kr = 0; kr < KERNEL_SIZE; kr++)
      for (int kc = 0; kc < KERNEL_SIZE; kc++)
        acc += 64'(win[kr][kc]) * 64'(coefs[kr*KERNEL_SIZE + kc]);
    if (COEF_BITS > 16) q = acc >> (COEF_BITS - 16);
    else q = acc << (16 - COEF_BITS);
    if (q > 64'(SAT_MAX)) begin
      want.filtered_value = SAT_MAX;
      want.saturated      = 1'b1;
    end else begin
      want.filtered_value = OUT_W'(q);
      want.saturated      = 1'b0;
    end
    want.out_row = COUNT_W'(r - LINES);
    want.out_col = COUNT_W'(c - LINES);
    conv_out_q.push_back(want);
  endfunction

  function automatic void compare_result(input result_t got);
    result_t want;
    if (conv_out_q.size() == 0) begin
      $error("unexpected result: row %0d col %0d value %0d",
             got.out_row, got.out_col, got.filtered_value);
      n_fail++;
      return;
    end
    want = conv_out_q.pop_front();
    n_checked++;
    if (got.filtered_value !== want.filtered_value) begin
      $error("filtered_value: expected %0d, got %0d (row %0d col %0d)",
             want.filtered_value, got.filtered_value, want.out_row, want.out_col);
      n_fail++;
    end
    if (got.out_row !== want.out_row) begin
      $error("out_row: expected %0d, got %0d", want.out_row, got.out_row);
      n_fail++;
    end
    if (got.out_col !== want.out_col) begin
      $error("out_col: expected %0d, got %0d", want.out_col, got.out_col);
      n_fail++;
    end
    if (got.saturated !== want.saturated) begin
      $error("saturated: expected %0b, got %0b (row %0d col %0d)",
             want.saturated, got.saturated, want.out_row, want.out_col);
      n_fail++;
    end
  endfunction

  // results are taken before this edge's item, so a fresh expectation
  // can never pair with an output already on the port
  always @(posedge clk) begin
    if (rst) begin
      clear_shadow();
      conv_out_q.delete();
    end else begin
      if ($isunknown(res_valid)) begin
        $error("res_valid: expected 0 or 1, got %b", res_valid);
        n_fail++;
      end else if (res_valid && !res_stall) begin
        compare_result(res_data);
      end
      if (cfg_valid && cfg_ready) width_reg = cfg_data;
      if (src_valid && !src_stall) begin
        if (src_data.command == CMD_LOAD) store_coef(src_data);
        else slide_pixel(src_data);
      end
    end
    pending    <= conv_out_q.size();
    fail_count <= n_fail;
    checked    <= n_checked;
  end

endmodule

// ----- tb/sv/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import c2dsw_pkg::*;

  localparam int LIMIT        = 1_000_000;  // cycle ceiling for the whole run
  localparam int RANDOM_ITEMS = 950;
  localparam int SETTLE       = 8;          // settling margin beyond the pipeline depth
  localparam int HOLD_CYCLES  = 300;        // long output back-pressure
  localparam int MAX_GAP      = 14;
  localparam int ITEM_W       = $bits(item_t);
  localparam int IDX_TOP      = (1 << IDX_W) - 1;

  // how a freshly loaded kernel is filled
  typedef enum int {
    K_ZERO,
    K_FULL,
    K_RANDOM,
    K_MODERATE,
    K_FAINT,
    K_SPARSE
  } kernel_mode_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             src_valid = 1'b0;
  logic             src_stall;
  item_t            src_data  = '0;
  logic             res_valid;
  logic             res_stall = 1'b0;
  result_t          res_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data  = '0;

  int pending;
  int fail_count;
  int checked;

  // sender pacing: runs of items either back to back or with random gaps
  int src_max_gap = MAX_GAP;
  int src_run_left;
  bit src_run_busy;
  int cur_width   = int'(PW_RESET);
  int n_items;
  int n_widths;
  int cycles;
  bit hold_req;

  conv2d_sliding_window_top u_top (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  conv2d_sliding_window_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .src_valid  (src_valid),
    .src_stall  (src_stall),
    .src_data   (src_data),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_data   (res_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .fail_count (fail_count),
    .checked    (checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // input side: one transfer per call, valid held high across back-to-back
  // items so it is never dropped and raised in the same step
  // ---------------------------------------------------------------------
  task automatic send(input item_t it);
    int gap;
    if (src_run_left == 0) begin
      src_run_left = $urandom_range(1, 40);
      src_run_busy = ($urandom_range(0, 3) == 0);
    end
    src_run_left--;
    gap = (src_run_busy || src_max_gap == 0) ? 0 : $urandom_range(0, src_max_gap);
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_data  <= it;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    // loads to a tap that does not exist are simply dropped by the block
    if (!(it.command == CMD_LOAD && it.coef_index >= TAPS)) n_items++;
  endtask

  // unused fields carry random bits so every input bit toggles
  function automatic item_t pixel_item(input logic [PIX_W-1:0] pix, input logic first);
    item_t it;
    it                = item_t'(ITEM_W'($urandom));
    it.command        = CMD_PIXEL;
    it.pixel          = pix;
    it.first_of_frame = first;
    return it;
  endfunction

  function automatic item_t coef_item(input logic [IDX_W-1:0] idx,
                                      input logic [COEFIN_W-1:0] val);
    item_t it;
    it            = item_t'(ITEM_W'($urandom));
    it.command    = CMD_LOAD;
    it.coef_index = idx;
    it.coef_value = val;
    return it;
  endfunction

  // extremes come up often, the rest is uniform
  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  task automatic load_kernel(input kernel_mode_t mode);
    logic [COEFIN_W-1:0] val;
    for (int i = 0; i < TAPS; i++) begin
      case (mode)
        K_ZERO:     val = '0;
        K_FULL:     val = '1;
        K_MODERATE: val = COEFIN_W'($urandom_range(0, 8191));
        K_FAINT:    val = COEFIN_W'($urandom_range(0, 1023));
        K_SPARSE:   val = ($urandom_range(0, 3) == 0) ? COEFIN_W'($urandom) : '0;
        default:    val = COEFIN_W'($urandom);
      endcase
      send(coef_item(IDX_W'(i), val));
      // now and then a load past the last tap, which must leave the kernel alone
      if ($urandom_range(0, 15) == 0)
        send(coef_item(IDX_W'($urandom_range(TAPS, IDX_TOP)), COEFIN_W'($urandom)));
    end
  endtask

  // rows of the current width; restart_at marks one pixel as a new frame,
  // noise_pct sprinkles fully random items between the pixels
  task automatic send_frame(input int rows, input bit marked, input int restart_at,
                            input int noise_pct);
    for (int p = 0; p < rows * cur_width; p++) begin
      send(pixel_item(rand_pixel(), (marked && p == 0) || p == restart_at));
      if (noise_pct != 0 && $urandom_range(0, 99) < noise_pct)
        send(item_t'(ITEM_W'($urandom)));
    end
  endtask

  // sender goes quiet until every filtered output is in, then lets any
  // load or early pixel still in the pipe settle
  task automatic drain();
    src_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_width(input logic [CFG_W-1:0] w);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (w == '0) cur_width = 1;
    else if (w > MAX_WIDTH) cur_width = MAX_WIDTH;
    else cur_width = int'(w);
    n_widths++;
  endtask

  // ---------------------------------------------------------------------
  // output side: a random stall before each transfer, runs with none, and
  // a long hold-off on request from the stimulus
  // ---------------------------------------------------------------------
  initial begin : receiver
    int wait_cycles;
    int run_left;
    bit run_busy;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (run_left == 0) begin
          run_left = $urandom_range(1, 40);
          run_busy = ($urandom_range(0, 3) == 0);
        end
        run_left--;
        wait_cycles = run_busy ? 0 : $urandom_range(0, MAX_GAP);
        if (wait_cycles > 0) begin
          res_stall <= 1'b1;
          repeat (wait_cycles) @(posedge clk);
        end
        res_stall <= 1'b0;
        @(posedge clk);
        while (!res_valid && !hold_req) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int start;
    int n_random;
    int rows;
    int restart;
    int w;
    bit new_width;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // narrowest useful row; stream starts without a frame mark
    set_width(CFG_W'(KERNEL_SIZE));
    send(coef_item(IDX_W'(TAPS), '1));
    send(coef_item(IDX_W'(IDX_TOP), '1));
    load_kernel(K_RANDOM);
    send(coef_item('0, '1));
    send(coef_item(IDX_W'(TAPS - 1), '0));
    send_frame(6, 1'b0, -1, 0);
    // frame mark in the middle of a row restarts both counters
    send_frame(7, 1'b1, 13, 0);

    // all-ones kernel saturates, all-zero gives zero, faint stays in range
    load_kernel(K_FULL);
    send_frame(6, 1'b1, -1, 0);
    load_kernel(K_ZERO);
    send_frame(5, 1'b1, -1, 0);
    load_kernel(K_FAINT);
    send_frame(5, 1'b1, -1, 0);

    // output held off for a long stretch while pixels keep coming, so the
    // pipeline fills and the input stalls
    load_kernel(K_MODERATE);
    src_max_gap = 0;
    hold_req    = 1'b1;
    send_frame(8, 1'b1, -1, 0);
    src_max_gap = MAX_GAP;

    // sender pause mid-frame until every output is in, then carry on
    send_frame(3, 1'b1, -1, 0);
    drain();
    send_frame(4, 1'b0, -1, 0);

    // rows narrower than the kernel, zero acting as one: never an output
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      set_width(CFG_W'(i));
      send_frame(6, 1'b1, -1, 0);
    end

    // random frames: mostly well-formed with random content, some unmarked,
    // restarted or peppered with random items; a new width always opens a
    // marked frame so line-buffer columns are filled before they are used
    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      start     = n_items;
      new_width = 1'b0;
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 9))
          0:       w = $urandom_range(0, KERNEL_SIZE - 1);
          1, 2:    w = $urandom_range(10, 24);
          default: w = $urandom_range(KERNEL_SIZE, 9);
        endcase
        set_width(CFG_W'(w));
        new_width = 1'b1;
      end
      if ($urandom_range(0, 3) == 0) load_kernel(kernel_mode_t'($urandom_range(0, 5)));
      rows    = $urandom_range(5, 9);
      restart = ($urandom_range(0, 7) == 0) ? $urandom_range(0, rows * cur_width - 1) : -1;
      send_frame(rows, new_width || ($urandom_range(0, 4) != 0), restart, 3);
      if ($urandom_range(0, 9) == 0) drain();
      n_random += n_items - start;
    end

    // all-ones width clamps to the widest row; a short marked run at full rate
    set_width('1);
    load_kernel(K_FAINT);
    src_max_gap = 0;
    for (int p = 0; p < 4 * KERNEL_SIZE; p++) begin
      send(pixel_item(rand_pixel(), p == 0));
    end
    src_max_gap = MAX_GAP;

    drain();
    repeat (4 * SETTLE) @(posedge clk);
    $display("run covered %0d items, %0d filtered outputs checked, %0d width writes",
             n_items, checked, n_widths);
    $display("incl. zero and all-ones width, stray loads, restarts and back-pressure");
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
